// ===== src/ualm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ualm_pkg: shared types and constants for the identifier allow-list
// Beat layouts, operation and status codes, table sizing, byte mask helper.
// ----------------------------------------------------------------------------
package ualm_pkg;

  localparam int MAX_ENTRIES   = 16;
  localparam int UID_MAX_BYTES = 10;
  localparam int UID_BITS      = 8 * UID_MAX_BYTES;
  localparam int CNT_W         = $clog2(MAX_ENTRIES + 1);
  localparam int IDX_W         = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  localparam logic [1:0] FUNC_CHECK = 2'd0;
  localparam logic [1:0] FUNC_ADD   = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_LEN = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  uid_length;
    logic [63:0] uid_low;
    logic [15:0] uid_high;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic       authorized;
    logic [4:0] entries_used;
  } out_item_t;

  // Table command for one beat; add and check arrive already length-qualified.
  typedef struct packed {
    logic        check;
    logic        add;
    logic        clear;
    logic [3:0]  uid_length;
    logic [63:0] uid_low;
    logic [15:0] uid_high;
  } table_op_t;

  typedef struct packed {
    logic             hit;
    logic             full;
    logic [CNT_W-1:0] count_next;
  } table_stat_t;

  // One byte lane set per byte covered by the length.
  function automatic logic [UID_BITS-1:0] uid_mask(input logic [3:0] len);
    logic [UID_BITS-1:0] m;
    m = '0;
    for (int b = 0; b < UID_MAX_BYTES; b++) begin
      m[b*8 +: 8] = {8{(4'(b) < len)}};
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== src/ualm_in_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ualm_in_if: request channel
// Valid/ready channel carrying one operation beat.
// ----------------------------------------------------------------------------
interface ualm_in_if;
  logic              valid;
  logic              ready;
  ualm_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/ualm_out_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ualm_out_if: response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
interface ualm_out_if;
  logic               valid;
  logic               ready;
  ualm_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/uid_allow_list_match_table_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uid_allow_list_match_table_core: card identifier allow-list
// Check, add and clear operations on a 16-entry associative match table.
// ----------------------------------------------------------------------------
// Usage
//   req: one beat per operation (func, uid_length, uid_low, uid_high).
//        func CHECK looks the identifier up, ADD appends it, CLEAR empties
//        the table (stored bytes stay, only the count drops to zero).
//   rsp: exactly one beat per request: status (ok / bad length / full),
//        authorized (check hit) and entries_used after the operation.
//   Path: a request beat lands in the input register when accepted; its
//        response is then registered in the response register, which
//        drives rsp.valid and rsp.data.
//   Throughput: one operation per cycle while rsp is not stalled. All entries
//        compare in parallel and a table update is visible to the very next beat.
//   Stall: when rsp is held off the response register keeps its beat, the
//        input register fills, and req.ready drops until rsp moves again.
//   Reset: rst (synchronous, active high) empties both pipeline registers
//        and sets the entry count to zero; entry storage is not cleared,
//        entries at or above the count are never compared.
// ----------------------------------------------------------------------------
module uid_allow_list_match_table_core (
  input  wire logic clk,
  input  wire logic rst,
  ualm_in_if.sink   req,
  ualm_out_if.source rsp
);

  // input register
  logic               in_valid;
  ualm_pkg::in_item_t in_data;
  // response register
  logic                out_valid;
  ualm_pkg::out_item_t out_data;
  ualm_pkg::out_item_t out_data_next;

  logic                  adv;
  logic                  len_ok;
  ualm_pkg::table_op_t   op;
  ualm_pkg::table_stat_t tstat;

  // Input register moves forward whenever the response slot is free or drains.
  assign adv       = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_data <= req.data;
    end
  end

  assign len_ok = (in_data.uid_length >= 4'd1) &&
                  (in_data.uid_length <= 4'(ualm_pkg::UID_MAX_BYTES));

  // Table only acts on a beat that actually advances.
  assign op.check      = adv && (in_data.func == ualm_pkg::FUNC_CHECK) && len_ok;
  assign op.add        = adv && (in_data.func == ualm_pkg::FUNC_ADD) && len_ok;
  assign op.clear      = adv && (in_data.func == ualm_pkg::FUNC_CLEAR);
  assign op.uid_length = in_data.uid_length;
  assign op.uid_low    = in_data.uid_low;
  assign op.uid_high   = in_data.uid_high;

  ualm_table u_table (
    .clk  (clk),
    .rst  (rst),
    .op   (op),
    .stat (tstat)
  );

  always_comb begin
    out_data_next.status       = ualm_pkg::ST_OK;
    out_data_next.authorized   = tstat.hit;
    out_data_next.entries_used = 5'(tstat.count_next);
    unique case (in_data.func)
      ualm_pkg::FUNC_CHECK: begin
        if (!len_ok) begin
          out_data_next.status = ualm_pkg::ST_BAD_LEN;
        end
      end
      ualm_pkg::FUNC_ADD: begin
        // bad length wins over full
        priority if (!len_ok) begin
          out_data_next.status = ualm_pkg::ST_BAD_LEN;
        end else if (tstat.full) begin
          out_data_next.status = ualm_pkg::ST_FULL;
        end else begin
          out_data_next.status = ualm_pkg::ST_OK;
        end
      end
      ualm_pkg::FUNC_CLEAR,
      ualm_pkg::FUNC_NOP: begin
        out_data_next.status = ualm_pkg::ST_OK;
      end
      default: begin
        out_data_next.status = ualm_pkg::ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || rsp.ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= out_data_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  a_auth_only_check: assert property (@(posedge clk) disable iff (rst)
    adv && (in_data.func != ualm_pkg::FUNC_CHECK) |=> !out_data.authorized)
    else $error("authorized set on a non-check operation");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    adv && (in_data.func == ualm_pkg::FUNC_CLEAR) |=>
      out_valid && (out_data.entries_used == 5'd0))
    else $error("clear did not report an empty table");

  a_full_at_depth: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_data.status == ualm_pkg::ST_FULL) |->
      (out_data.entries_used == 5'(ualm_pkg::MAX_ENTRIES)))
    else $error("table full reported below depth");

  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rsp.ready |-> !adv)
    else $error("response overwritten while stalled");

endmodule
`default_nettype wire

// ===== src/ualm_table.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ualm_table: entry storage with parallel match
// Every entry has its own comparator; add writes at the count, clear zeroes it.
// ----------------------------------------------------------------------------
module ualm_table (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire ualm_pkg::table_op_t     op,
  output      ualm_pkg::table_stat_t   stat
);

  logic [63:0]                  entry_low  [ualm_pkg::MAX_ENTRIES];
  logic [15:0]                  entry_high [ualm_pkg::MAX_ENTRIES];
  logic [3:0]                   entry_len  [ualm_pkg::MAX_ENTRIES];
  logic [ualm_pkg::CNT_W-1:0]   count;
  logic [ualm_pkg::CNT_W-1:0]   count_next;
  logic [ualm_pkg::MAX_ENTRIES-1:0] lane_hit;
  logic [ualm_pkg::UID_BITS-1:0]    mask;
  logic                         full;
  logic                         do_add;

  assign mask   = ualm_pkg::uid_mask(op.uid_length);
  assign full   = (count == ualm_pkg::CNT_W'(ualm_pkg::MAX_ENTRIES));
  assign do_add = op.add && !full;

  for (genvar i = 0; i < ualm_pkg::MAX_ENTRIES; i++) begin : g_lane
    assign lane_hit[i] = (ualm_pkg::CNT_W'(i) < count) &&
                         (entry_len[i] == op.uid_length) &&
                         (((entry_low[i] ^ op.uid_low) & mask[63:0]) == '0) &&
                         (((entry_high[i] ^ op.uid_high) & mask[79:64]) == '0);
  end

  always_comb begin
    priority if (op.clear) begin
      count_next = '0;
    end else if (do_add) begin
      count_next = count + ualm_pkg::CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (do_add) begin
      entry_low[count[ualm_pkg::IDX_W-1:0]]  <= op.uid_low;
      entry_high[count[ualm_pkg::IDX_W-1:0]] <= op.uid_high;
      entry_len[count[ualm_pkg::IDX_W-1:0]]  <= op.uid_length;
    end
  end

  assign stat.hit        = op.check && (|lane_hit);
  assign stat.full       = full;
  assign stat.count_next = count_next;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ualm_pkg::CNT_W'(ualm_pkg::MAX_ENTRIES))
    else $error("entry count above table depth");

  a_empty_no_hit: assert property (@(posedge clk) disable iff (rst)
    (count == '0) |-> !stat.hit)
    else $error("match reported on an empty table");

endmodule
`default_nettype wire
